>>> hdl/camera_ray_generator_core_assert.svh
// assertion macros for the camera ray generator core
`ifndef CAMERA_RAY_GENERATOR_CORE_ASSERT_SVH
`define CAMERA_RAY_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define CRG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CRG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CRG_ASSERT(lbl, prop, msg)
`define CRG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/crg_pkg.sv
// shared types and constants of the camera ray generator
package crg_pkg;

   localparam int PIXEL_W      = 12;
   localparam int SIZE_W       = 13;
   localparam int SCALE_W      = 20;
   localparam int NEAR_W       = 24;
   localparam int ORIGIN_W     = 29;
   localparam int ORIGIN_Z_W   = 25;
   localparam int DIR_W        = 18;
   localparam int DIR_Z_W      = 17;
   localparam int NORM_W       = 30;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH      = 3'd0,
      REG_FRAME_HEIGHT     = 3'd1,
      REG_SCALE_HORIZONTAL = 3'd2,
      REG_SCALE_VERTICAL   = 3'd3,
      REG_NEAR_DISTANCE    = 3'd4
   } csr_index_type;

   localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH      = 13'd640;
   localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT     = 13'd480;
   localparam logic [SCALE_W-1:0] RST_SCALE_HORIZONTAL = 20'd50449;
   localparam logic [SCALE_W-1:0] RST_SCALE_VERTICAL   = 20'd37837;
   localparam logic [NEAR_W-1:0]  RST_NEAR_DISTANCE    = 24'd6554;

endpackage

>>> hdl/crg_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module crg_div #(
   parameter int NUM_W  = 30,
   parameter int DEN_W  = 13,
   parameter int QUO_W  = 30,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int CMP_W = NUM_W + DEN_W + QUO_W;

   logic [NUM_W-1:0]  rem_ff  [0:QUO_W-1];
   logic [DEN_W-1:0]  den_ff  [0:QUO_W-1];
   logic [QUO_W-1:0]  quo_ff  [0:QUO_W];
   logic [SIDE_W-1:0] side_ff [0:QUO_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         quo_ff[0]  <= '0;
         side_ff[0] <= side;
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int B = QUO_W - 1 - s;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] rem_ext;
      logic [CMP_W-1:0] rem_in;
      logic             ge;

      assign trial   = {{(CMP_W-DEN_W){1'b0}}, den_ff[s]} << B;
      assign rem_ext = {{(CMP_W-NUM_W){1'b0}}, rem_ff[s]};
      assign ge      = rem_ext >= trial;
      assign rem_in  = ge ? (rem_ext - trial) : rem_ext;

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[s+1]  <= {quo_ff[s][QUO_W-2:0], ge};
            side_ff[s+1] <= side_ff[s];
         end
      end

      if (s < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s+1] <= rem_in[NUM_W-1:0];
               den_ff[s+1] <= den_ff[s];
            end
         end
      end
   end

   assign quo      = quo_ff[QUO_W];
   assign side_out = side_ff[QUO_W];

endmodule

>>> hdl/camera_ray_generator_core.sv
// top level of the pinhole camera ray generator pipeline
//
//  channel | signals                        | direction
//  req     | req_valid/ready, pixel x and y | in
//  rsp     | rsp_valid/ready, origin, dir   | out
//  csr     | csr_valid/ready, index, data   | in
//
// one transfer per cycle while the output is not stalled; the pipeline holds
// the pixel divider, the 31 step square root and the unit divider
// synchronous reset empties the pipeline and loads the register defaults
// a stalled output freezes the whole pipeline; csr is always ready
`include "camera_ray_generator_core_assert.svh"
module camera_ray_generator_core
   import crg_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [PIXEL_W-1:0]            req_pixel_x,
   input  logic [PIXEL_W-1:0]            req_pixel_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ORIGIN_W-1:0]    rsp_origin_x,
   output logic signed [ORIGIN_W-1:0]    rsp_origin_y,
   output logic signed [ORIGIN_Z_W-1:0]  rsp_origin_z,
   output logic signed [DIR_W-1:0]       rsp_direction_x,
   output logic signed [DIR_W-1:0]       rsp_direction_y,
   output logic signed [DIR_Z_W-1:0]     rsp_direction_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int F          = FRACTION_BITS;
   localparam int NDC_W      = F + 14;
   localparam int PROD_W     = NDC_W + SCALE_W;
   localparam int TX_W       = PROD_W - F + 1;
   localparam int LO_W       = 18;
   localparam int HI_W       = TX_W - LO_W;
   localparam int OSUM_W     = TX_W + NEAR_W + 1;
   localparam int OMAG_W     = OSUM_W - F;
   localparam int K_MAX      = TX_W - NORM_W;
   localparam int K_W        = $clog2(K_MAX + 1);
   localparam int SQ_W       = 2 * NORM_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int STEPS      = SUM_W / 2;
   localparam int LEN_W      = STEPS;
   localparam int UNUM_W     = NORM_W + F + 1;
   localparam int UQ_W       = F + 1;
   localparam int SIDE_W     = 2 * ORIGIN_W + 2;
   localparam int SQS_W      = 3 * NORM_W + SIDE_W;
   localparam int DSAT_W     = UQ_W + DIR_W;
   localparam int VL         = NDC_W + STEPS + UQ_W + 8;
   localparam int LVL_SQ_END = NDC_W + 6 + STEPS;

   localparam logic [NDC_W-1:0]  NDC_ONE   = NDC_W'(1) << F;
   localparam logic [PROD_W:0]   PROD_HALF = (PROD_W+1)'(1) << (F - 1);
   localparam logic [OSUM_W-1:0] OSUM_HALF = OSUM_W'(1) << (F - 1);
   localparam logic [NORM_W-1:0] NORM_ONE  = NORM_W'(1) << F;
   localparam logic [OMAG_W-1:0] ORG_POS   = OMAG_W'((64'd1 << (ORIGIN_W - 1)) - 64'd1);
   localparam logic [OMAG_W-1:0] ORG_NEG   = OMAG_W'(64'd1 << (ORIGIN_W - 1));
   localparam logic [DSAT_W-1:0] DIR_POS   = DSAT_W'((64'd1 << (DIR_W - 1)) - 64'd1);
   localparam logic [DSAT_W-1:0] DIR_NEG   = DSAT_W'(64'd1 << (DIR_W - 1));
   localparam logic [DSAT_W-1:0] DIR_Z_NEG = DSAT_W'(64'd1 << (DIR_Z_W - 1));

   function automatic logic [ORIGIN_W-1:0] sat_origin(input logic [OMAG_W-1:0] mag,
                                                       input logic neg);
      logic [OMAG_W-1:0]   lim;
      logic [ORIGIN_W-1:0] m;
      lim = neg ? ORG_NEG : ORG_POS;
      m   = (mag > lim) ? lim[ORIGIN_W-1:0] : mag[ORIGIN_W-1:0];
      return neg ? (~m + 1'b1) : m;
   endfunction

   function automatic logic [DSAT_W-1:0] sat_dir(input logic [UQ_W-1:0] q,
                                                  input logic neg,
                                                  input logic [DSAT_W-1:0] lim);
      logic [DSAT_W-1:0] m;
      m = {{DIR_W{1'b0}}, q};
      m = (m > lim) ? lim : m;
      return neg ? (~m + 1'b1) : m;
   endfunction

   // configuration registers
   logic [SIZE_W-1:0]  frame_width_ff, frame_height_ff;
   logic [SCALE_W-1:0] scale_h_ff, scale_v_ff;
   logic [NEAR_W-1:0]  near_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         scale_h_ff      <= RST_SCALE_HORIZONTAL;
         scale_v_ff      <= RST_SCALE_VERTICAL;
         near_ff         <= RST_NEAR_DISTANCE;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_FRAME_WIDTH:      frame_width_ff  <= csr_data[SIZE_W-1:0];
            REG_FRAME_HEIGHT:     frame_height_ff <= csr_data[SIZE_W-1:0];
            REG_SCALE_HORIZONTAL: scale_h_ff      <= csr_data[SCALE_W-1:0];
            REG_SCALE_VERTICAL:   scale_v_ff      <= csr_data[SCALE_W-1:0];
            REG_NEAR_DISTANCE:    near_ff         <= csr_data[NEAR_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic          adv;
   logic [VL-1:0] vld_ff;
   logic          rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VL-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VL-1];
      end
   end

   // pixel to ndc division
   logic [SIZE_W-1:0] width_eff, height_eff;
   logic [NDC_W-1:0]  ndc_num_x, ndc_num_y, qx, qy;
   logic              ndc_side_x, ndc_side_y;

   assign width_eff  = (frame_width_ff == '0) ? SIZE_W'(1) : frame_width_ff;
   assign height_eff = (frame_height_ff == '0) ? SIZE_W'(1) : frame_height_ff;
   assign ndc_num_x  = {1'b0, req_pixel_x, {(F+1){1'b0}}}
                     + {{(NDC_W-SIZE_W+1){1'b0}}, width_eff[SIZE_W-1:1]};
   assign ndc_num_y  = {1'b0, req_pixel_y, {(F+1){1'b0}}}
                     + {{(NDC_W-SIZE_W+1){1'b0}}, height_eff[SIZE_W-1:1]};

   crg_div #(.NUM_W(NDC_W), .DEN_W(SIZE_W), .QUO_W(NDC_W), .SIDE_W(1)) u_ndc_x (
      .clock(clock), .enable(adv), .num(ndc_num_x), .den(width_eff),
      .side(1'b0), .quo(qx), .side_out(ndc_side_x)
   );

   crg_div #(.NUM_W(NDC_W), .DEN_W(SIZE_W), .QUO_W(NDC_W), .SIDE_W(1)) u_ndc_y (
      .clock(clock), .enable(adv), .num(ndc_num_y), .den(height_eff),
      .side(1'b0), .quo(qy), .side_out(ndc_side_y)
   );

   // stage a: sign and magnitude of ndc
   logic             a_negx_ff, a_negy_ff;
   logic [NDC_W-1:0] a_nx_ff, a_ny_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a_negx_ff <= (qx < NDC_ONE) && !ndc_side_x;
         a_negy_ff <= (qy < NDC_ONE) && !ndc_side_y;
         a_nx_ff   <= (qx < NDC_ONE) ? (NDC_ONE - qx) : (qx - NDC_ONE);
         a_ny_ff   <= (qy < NDC_ONE) ? (NDC_ONE - qy) : (qy - NDC_ONE);
      end
   end

   // stage b: tangent scale products
   logic              b_negx_ff, b_negy_ff;
   logic [PROD_W-1:0] b_px_ff, b_py_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         b_negx_ff <= a_negx_ff;
         b_negy_ff <= a_negy_ff;
         b_px_ff   <= a_nx_ff * scale_h_ff;
         b_py_ff   <= a_ny_ff * scale_v_ff;
      end
   end

   // stage c: round slopes
   logic [PROD_W:0] c_rx, c_ry;
   logic            c_negx_ff, c_negy_ff;
   logic [TX_W-1:0] c_tx_ff, c_ty_ff;

   assign c_rx = {1'b0, b_px_ff} + PROD_HALF;
   assign c_ry = {1'b0, b_py_ff} + PROD_HALF;

   always_ff @(posedge clock) begin
      if (adv) begin
         c_negx_ff <= b_negx_ff;
         c_negy_ff <= b_negy_ff;
         c_tx_ff   <= c_rx[PROD_W:F];
         c_ty_ff   <= c_ry[PROD_W:F];
      end
   end

   // stage d: normalize shift and origin partial products
   logic [TX_W-1:0]        d_m;
   logic [K_W-1:0]         d_k;
   logic                   d_negx_ff, d_negy_ff;
   logic [NORM_W-1:0]      d_a_ff, d_b_ff, d_c_ff;
   logic [LO_W+NEAR_W-1:0] d_oxl_ff, d_oyl_ff;
   logic [HI_W+NEAR_W-1:0] d_oxh_ff, d_oyh_ff;

   assign d_m = c_tx_ff | c_ty_ff;

   always_comb begin
      d_k = '0;
      for (int j = NORM_W; j < TX_W; j++) begin
         if (d_m[j]) begin
            d_k = K_W'(j - NORM_W + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_negx_ff <= c_negx_ff && (c_tx_ff != '0);
         d_negy_ff <= c_negy_ff && (c_ty_ff != '0);
         d_a_ff    <= NORM_W'(c_tx_ff >> d_k);
         d_b_ff    <= NORM_W'(c_ty_ff >> d_k);
         d_c_ff    <= NORM_ONE >> d_k;
         d_oxl_ff  <= c_tx_ff[LO_W-1:0] * near_ff;
         d_oxh_ff  <= c_tx_ff[TX_W-1:LO_W] * near_ff;
         d_oyl_ff  <= c_ty_ff[LO_W-1:0] * near_ff;
         d_oyh_ff  <= c_ty_ff[TX_W-1:LO_W] * near_ff;
      end
   end

   // stage e: squares and final origin
   logic [OSUM_W-1:0]   e_sx, e_sy;
   logic                e_negx_ff, e_negy_ff;
   logic [NORM_W-1:0]   e_a_ff, e_b_ff, e_c_ff;
   logic [SQ_W-1:0]     e_aa_ff, e_bb_ff, e_cc_ff;
   logic [ORIGIN_W-1:0] e_ox_ff, e_oy_ff;

   assign e_sx = OSUM_W'(d_oxl_ff) + (OSUM_W'(d_oxh_ff) << LO_W) + OSUM_HALF;
   assign e_sy = OSUM_W'(d_oyl_ff) + (OSUM_W'(d_oyh_ff) << LO_W) + OSUM_HALF;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_negx_ff <= d_negx_ff;
         e_negy_ff <= d_negy_ff;
         e_a_ff    <= d_a_ff;
         e_b_ff    <= d_b_ff;
         e_c_ff    <= d_c_ff;
         e_aa_ff   <= d_a_ff * d_a_ff;
         e_bb_ff   <= d_b_ff * d_b_ff;
         e_cc_ff   <= d_c_ff * d_c_ff;
         e_ox_ff   <= sat_origin(e_sx[OSUM_W-1:F], d_negx_ff);
         e_oy_ff   <= sat_origin(e_sy[OSUM_W-1:F], d_negy_ff);
      end
   end

   // square root pipeline, two radicand bits per stage
   logic [SUM_W-1:0] sq_x_ff    [0:STEPS-1];
   logic [SUM_W-1:0] sq_r_ff    [0:STEPS];
   logic [SQS_W-1:0] sq_side_ff [0:STEPS];
   logic [LEN_W-1:0] sq_len;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_x_ff[0]    <= SUM_W'(e_aa_ff) + SUM_W'(e_bb_ff) + SUM_W'(e_cc_ff);
         sq_r_ff[0]    <= '0;
         sq_side_ff[0] <= {e_a_ff, e_b_ff, e_c_ff, e_ox_ff, e_oy_ff, e_negx_ff, e_negy_ff};
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (STEPS - 1 - i));
      logic [SUM_W-1:0] t;
      logic             ge;

      assign t  = sq_r_ff[i] + BIT;
      assign ge = sq_x_ff[i] >= t;

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_r_ff[i+1]    <= ge ? ((sq_r_ff[i] >> 1) + BIT) : (sq_r_ff[i] >> 1);
            sq_side_ff[i+1] <= sq_side_ff[i];
         end
      end

      if (i < STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_x_ff[i+1] <= ge ? (sq_x_ff[i] - t) : sq_x_ff[i];
            end
         end
      end
   end

   assign sq_len = sq_r_ff[STEPS][LEN_W-1:0];

   // unit vector division
   logic [NORM_W-1:0] u_a, u_b, u_c;
   logic [SIDE_W-1:0] u_side, u_side_out;
   logic [UNUM_W-1:0] u_num_x, u_num_y, u_num_z, u_half;
   logic [UQ_W-1:0]   ux, uy, uz;
   logic              uy_side, uz_side;

   assign {u_a, u_b, u_c, u_side} = sq_side_ff[STEPS];
   assign u_half  = {{(UNUM_W-LEN_W+1){1'b0}}, sq_len[LEN_W-1:1]};
   assign u_num_x = {1'b0, u_a, {F{1'b0}}} + u_half;
   assign u_num_y = {1'b0, u_b, {F{1'b0}}} + u_half;
   assign u_num_z = {1'b0, u_c, {F{1'b0}}} + u_half;

   crg_div #(.NUM_W(UNUM_W), .DEN_W(LEN_W), .QUO_W(UQ_W), .SIDE_W(SIDE_W)) u_unit_x (
      .clock(clock), .enable(adv), .num(u_num_x), .den(sq_len),
      .side(u_side), .quo(ux), .side_out(u_side_out)
   );

   crg_div #(.NUM_W(UNUM_W), .DEN_W(LEN_W), .QUO_W(UQ_W), .SIDE_W(1)) u_unit_y (
      .clock(clock), .enable(adv), .num(u_num_y), .den(sq_len),
      .side(1'b0), .quo(uy), .side_out(uy_side)
   );

   crg_div #(.NUM_W(UNUM_W), .DEN_W(LEN_W), .QUO_W(UQ_W), .SIDE_W(1)) u_unit_z (
      .clock(clock), .enable(adv), .num(u_num_z), .den(sq_len),
      .side(1'b0), .quo(uz), .side_out(uz_side)
   );

   // output register
   logic [ORIGIN_W-1:0]   o_ox, o_oy;
   logic                  o_negx, o_negy;
   logic [DSAT_W-1:0]     o_dx, o_dy, o_dz;
   logic [ORIGIN_W-1:0]   rsp_origin_x_ff, rsp_origin_y_ff;
   logic [ORIGIN_Z_W-1:0] rsp_origin_z_ff;
   logic [DIR_W-1:0]      rsp_direction_x_ff, rsp_direction_y_ff;
   logic [DIR_Z_W-1:0]    rsp_direction_z_ff;

   assign {o_ox, o_oy, o_negx, o_negy} = u_side_out;
   assign o_dx = sat_dir(ux, o_negx, o_negx ? DIR_NEG : DIR_POS);
   assign o_dy = sat_dir(uy, o_negy, o_negy ? DIR_NEG : DIR_POS);
   assign o_dz = sat_dir(uz, !(uy_side || uz_side), DIR_Z_NEG);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_origin_x_ff    <= o_ox;
         rsp_origin_y_ff    <= o_oy;
         rsp_origin_z_ff    <= ~{1'b0, near_ff} + 1'b1;
         rsp_direction_x_ff <= o_dx[DIR_W-1:0];
         rsp_direction_y_ff <= o_dy[DIR_W-1:0];
         rsp_direction_z_ff <= o_dz[DIR_Z_W-1:0];
      end
   end

   assign rsp_origin_x    = rsp_origin_x_ff;
   assign rsp_origin_y    = rsp_origin_y_ff;
   assign rsp_origin_z    = rsp_origin_z_ff;
   assign rsp_direction_x = rsp_direction_x_ff;
   assign rsp_direction_y = rsp_direction_y_ff;
   assign rsp_direction_z = rsp_direction_z_ff;

   `CRG_ASSERT(a_len_nonzero, vld_ff[LVL_SQ_END] |-> (sq_len != '0), "zero vector length")
   `CRG_ASSERT(a_stall_freeze, !adv |=> $stable(vld_ff), "pipeline moved during stall")
   `CRG_ASSERT(a_dir_z_nonpos, rsp_valid_ff |-> (rsp_direction_z <= 0), "direction z positive")
   `CRG_ASSERT_ALWAYS(a_reset_empty, reset |=> (!rsp_valid_ff && vld_ff == '0), "pipeline not empty after reset")

endmodule
